// ===== hdl/bijective_template_matcher_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bijective template matcher
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef BIJECTIVE_TEMPLATE_MATCHER_ASSERT_SVH
`define BIJECTIVE_TEMPLATE_MATCHER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define BTM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define BTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bjm_pkg.sv =====
// ----------------------------------------------------------------------------
// bjm_pkg
// Shared types, codes and defaults of the bijective template matcher.
// ----------------------------------------------------------------------------
package bjm_pkg;

  localparam int TEMPLATE_DEPTH_DEF = 1024;
  localparam int SYMBOL_CELLS_DEF   = 32;
  localparam int SYM_W              = 8;
  localparam int VAL_W              = 32;
  localparam int CMD_W              = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SYMBOL = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    VERDICT_MATCH     = 3'd0,
    VERDICT_LENGTH    = 3'd1,
    VERDICT_CONFLICT  = 3'd2,
    VERDICT_REUSED    = 3'd3,
    VERDICT_EXHAUSTED = 3'd4
  } verdict_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOOK = 1'b1
  } state_t;

  // One symbol/value pair as held in a cell and passed along the chain.
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
    logic [VAL_W-1:0] val;
  } pair_t;

  // Per-cell compare flags.
  typedef struct packed {
    logic sym;
    logic val;
  } hit_t;

endpackage

// ===== hdl/bjm_ram.sv =====
// ----------------------------------------------------------------------------
// bjm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bjm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bjm_cell.sv =====
// ----------------------------------------------------------------------------
// bjm_cell
// One pair cell: holds a symbol/value pair, compares it with the query and
// takes its neighbour's pair when the chain shifts.
// ----------------------------------------------------------------------------
module bjm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic                      shift,
  input  bjm_pkg::pair_t            pair_i,
  input  logic [bjm_pkg::SYM_W-1:0] q_sym,
  input  logic [bjm_pkg::VAL_W-1:0] q_val,
  output bjm_pkg::pair_t            pair_o,
  output bjm_pkg::hit_t             hit_o
);

  logic                      valid_r;
  logic [bjm_pkg::SYM_W-1:0] sym_r;
  logic [bjm_pkg::VAL_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= pair_i.valid;
    end
  end

  // payload needs no reset: guarded by valid_r
  always_ff @(posedge clk) begin
    if (shift) begin
      sym_r <= pair_i.sym;
      val_r <= pair_i.val;
    end
  end

  assign pair_o.valid = valid_r;
  assign pair_o.sym   = sym_r;
  assign pair_o.val   = val_r;

  assign hit_o.sym = valid_r && (sym_r == q_sym);
  assign hit_o.val = valid_r && (val_r == q_val);

endmodule

// ===== hdl/bijective_template_matcher.sv =====
// ----------------------------------------------------------------------------
// bijective_template_matcher
// Loads a template of signed values, then checks streamed strings for a
// one-to-one mapping of symbols onto the template, one verdict per string.
// ----------------------------------------------------------------------------
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | tuser: cmd; tdata: symbol, template_value; tlast
//  out_    | master    | tdata: verdict, matched (zero padded to a byte)
//
//  Clear and append beats are taken in IDLE. A symbol beat is accepted in
//  IDLE, where the template entry is read from the store RAM (registered
//  read); the pair cell chain is then searched and updated in LOOK.
//  Reset (rst_n low, synchronous) empties the template, the string position
//  and every pair cell; the template store itself is not cleared.
//  A final symbol holds in the search cycle while an earlier verdict is still
//  waiting on out_tready; other beats are never held by the output side.
//
module bijective_template_matcher #(
  parameter int TEMPLATE_DEPTH = bjm_pkg::TEMPLATE_DEPTH_DEF,
  parameter int SYMBOL_CELLS   = bjm_pkg::SYMBOL_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] symbol, [39:8] template_value
  input  logic        in_tlast,   // last symbol of the string
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [2:0] verdict, [3] matched, [7:4] zero
);

  `include "bijective_template_matcher_assert.svh"

  // store address width and position width (position saturates at depth+1)
  localparam int AW = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;
  localparam int PW = $clog2(TEMPLATE_DEPTH + 2);
  localparam logic [PW-1:0] DEPTH_P = PW'(TEMPLATE_DEPTH);

  // --------------------------------------------------------------------------
  // Unpack the input beat
  // --------------------------------------------------------------------------
  logic [bjm_pkg::SYM_W-1:0] in_symbol;
  logic [bjm_pkg::VAL_W-1:0] in_value;
  logic                      in_acc;

  assign in_symbol = in_tdata[7:0];
  assign in_value  = in_tdata[39:8];
  assign in_acc    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  bjm_pkg::state_t           state_r, state_nxt;
  logic [PW-1:0]             tlen_r;
  logic [PW-1:0]             spos_r;
  bjm_pkg::verdict_t         err_r;
  logic                      map_r;      // this symbol is checked against a pair
  logic                      last_r;
  logic                      lenbad_r;   // string length differs from template
  logic [bjm_pkg::SYM_W-1:0] sym_r;
  logic [AW-1:0]             look_addr_r; // store entry of the symbol in search

  logic                      out_tvalid_r;
  bjm_pkg::verdict_t         out_verdict_r;

  logic                      look_done;
  logic                      start_str;
  logic [PW-1:0]             spos_inc;

  // --------------------------------------------------------------------------
  // Template store
  // --------------------------------------------------------------------------
  logic                      ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [bjm_pkg::VAL_W-1:0] ram_rdata;

  assign ram_we = in_acc && (in_tuser == bjm_pkg::CMD_APPEND) && (tlen_r < DEPTH_P);

  // hold the read address on the searched entry so a held search keeps its value
  assign ram_raddr = (state_r == bjm_pkg::ST_LOOK) ? look_addr_r : spos_r[AW-1:0];

  bjm_ram #(
    .WIDTH (bjm_pkg::VAL_W),
    .DEPTH (TEMPLATE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tlen_r[AW-1:0]),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Pair cell chain: a new pair enters cell 0 and the rest shift one place
  // --------------------------------------------------------------------------
  bjm_pkg::pair_t            chain [SYMBOL_CELLS+1];
  logic [SYMBOL_CELLS-1:0]   sym_hits;
  logic [SYMBOL_CELLS-1:0]   val_hits;
  logic                      cell_shift;

  assign chain[0].valid = 1'b1;
  assign chain[0].sym   = sym_r;
  assign chain[0].val   = ram_rdata;

  for (genvar gi = 0; gi < SYMBOL_CELLS; gi++) begin : g_cell
    bjm_pkg::hit_t hit;

    bjm_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clear  (start_str),
      .shift  (cell_shift),
      .pair_i (chain[gi]),
      .q_sym  (sym_r),
      .q_val  (ram_rdata),
      .pair_o (chain[gi+1]),
      .hit_o  (hit)
    );

    assign sym_hits[gi] = hit.sym;
    assign val_hits[gi] = hit.val;
  end

  // --------------------------------------------------------------------------
  // Search outcome
  // --------------------------------------------------------------------------
  logic              any_sym;
  logic              any_val;
  logic              agree;
  logic              full;
  logic              insert;
  bjm_pkg::verdict_t eval_err;
  bjm_pkg::verdict_t err_nxt;
  bjm_pkg::verdict_t verdict_nxt;

  assign any_sym = |sym_hits;
  assign any_val = |val_hits;
  assign agree   = |(sym_hits & val_hits);
  assign full    = chain[SYMBOL_CELLS].valid;

  // a known symbol must keep its value; a new symbol needs a free value
  // and a free cell
  always_comb begin
    if (any_sym) begin
      eval_err = agree ? bjm_pkg::VERDICT_MATCH : bjm_pkg::VERDICT_CONFLICT;
    end else if (any_val) begin
      eval_err = bjm_pkg::VERDICT_REUSED;
    end else if (full) begin
      eval_err = bjm_pkg::VERDICT_EXHAUSTED;
    end else begin
      eval_err = bjm_pkg::VERDICT_MATCH;
    end
  end

  assign insert      = map_r && !any_sym && !any_val && !full;
  assign err_nxt     = map_r ? eval_err : err_r;
  // length mismatch wins over any mapping failure
  assign verdict_nxt = lenbad_r ? bjm_pkg::VERDICT_LENGTH : err_nxt;

  // --------------------------------------------------------------------------
  // State machine: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bjm_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == bjm_pkg::CMD_SYMBOL)) begin
          state_nxt = bjm_pkg::ST_LOOK;
        end
      end
      bjm_pkg::ST_LOOK: begin
        if (look_done) begin
          state_nxt = bjm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bjm_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // State machine: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    look_done = 1'b0;
    unique case (state_r)
      bjm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      bjm_pkg::ST_LOOK: begin
        // hold a final symbol while the previous verdict is not yet taken
        look_done = !(last_r && out_tvalid_r && !out_tready);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign start_str  = in_acc && (in_tuser == bjm_pkg::CMD_SYMBOL) && (spos_r == '0);
  assign cell_shift = look_done && insert;
  assign spos_inc   = (spos_r <= DEPTH_P) ? PW'(spos_r + 1'b1) : spos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bjm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Template length and string position
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r <= '0;
      spos_r <= '0;
    end else if (in_acc) begin
      case (in_tuser)
        bjm_pkg::CMD_CLEAR: begin
          // also abandon any string in progress
          tlen_r <= '0;
          spos_r <= '0;
        end
        bjm_pkg::CMD_APPEND: begin
          if (tlen_r < DEPTH_P) begin
            tlen_r <= PW'(tlen_r + 1'b1);
          end
        end
        bjm_pkg::CMD_SYMBOL: begin
          spos_r <= in_tlast ? '0 : spos_inc;
        end
        default: begin
          tlen_r <= tlen_r;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Per-symbol context and first failure of the string
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= bjm_pkg::VERDICT_MATCH;
    end else if (start_str) begin
      err_r <= bjm_pkg::VERDICT_MATCH;
    end else if (look_done) begin
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == bjm_pkg::CMD_SYMBOL)) begin
      // symbols past the template, or after a failure, only count length
      map_r       <= ((spos_r == '0) || (err_r == bjm_pkg::VERDICT_MATCH)) &&
                     (spos_r < tlen_r);
      last_r      <= in_tlast;
      lenbad_r    <= (spos_inc != tlen_r);
      sym_r       <= in_symbol;
      look_addr_r <= spos_r[AW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (look_done && last_r) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_done && last_r) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, (out_verdict_r == bjm_pkg::VERDICT_MATCH), out_verdict_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BTM_ASSERT_SAME(a_one_sym_hit, state_r == bjm_pkg::ST_LOOK, $countones(sym_hits) <= 1, "symbol held by two pair cells")
  `BTM_ASSERT_SAME(a_one_val_hit, state_r == bjm_pkg::ST_LOOK && map_r, $countones(val_hits) <= 1, "value held by two pair cells")
  `BTM_ASSERT_NEXT(a_sym_to_look, in_acc && (in_tuser == bjm_pkg::CMD_SYMBOL), state_r == bjm_pkg::ST_LOOK, "symbol beat did not start a search")
  `BTM_ASSERT_SAME(a_result_from_look, $rose(out_tvalid_r), $past(state_r == bjm_pkg::ST_LOOK && last_r), "verdict raised outside a final search")

endmodule
